@@ sv/csvg_pkg.sv @@
// ----------------------------------------------------------------------------
// csvg_pkg: shared types and constants for the cube-sphere vertex generator
// Fixed-point constants, pipeline depths and per-stage step functions.
// ----------------------------------------------------------------------------
`default_nettype none

package csvg_pkg;

   // grid limits
   localparam logic [6:0] MIN_ROW_POINTS = 7'd2;
   localparam logic [6:0] MAX_ROW_POINTS = 7'd64;

   // register indexes on the csr channel
   localparam logic CSR_POINTS = 1'b0;
   localparam logic CSR_RADIUS = 1'b1;

   // reset values
   localparam logic [6:0]  POINTS_RESET = 7'd12;
   localparam logic [14:0] RADIUS_RESET = 15'd794;

   // face codes
   localparam logic [2:0] FACE_PX = 3'd0;
   localparam logic [2:0] FACE_NX = 3'd1;
   localparam logic [2:0] FACE_PY = 3'd2;
   localparam logic [2:0] FACE_NY = 3'd3;
   localparam logic [2:0] FACE_PZ = 3'd4;
   localparam logic [2:0] FACE_NZ = 3'd5;

   // Q1.30 constants
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
   localparam logic [29:0] PI4_Q30 = 30'd843314857;

   // reciprocals for exact floor division of a 30-bit value: ceil(2^(30+l)/d)
   localparam logic [30:0] RCP_42 = 31'(((64'd1 << 36) + 64'd41) / 64'd42);
   localparam logic [30:0] RCP_20 = 31'(((64'd1 << 35) + 64'd19) / 64'd20);
   localparam logic [30:0] RCP_6  = 31'(((64'd1 << 33) + 64'd5) / 64'd6);
   localparam logic [30:0] RCP_56 = 31'(((64'd1 << 36) + 64'd55) / 64'd56);
   localparam logic [30:0] RCP_30 = 31'(((64'd1 << 35) + 64'd29) / 64'd30);
   localparam logic [30:0] RCP_12 = 31'(((64'd1 << 34) + 64'd11) / 64'd12);

   localparam logic [14:0] Q15_MAX = 15'h7FFF;

   // pipeline shape
   localparam int ANG_STAGES = 6;   // 5 quotient bits per stage, 30 bits
   localparam int ANG_STEPS  = 5;
   localparam int TRIG_LAT   = 8;
   localparam int SQ_STAGES  = 8;   // 4 root bits per stage, 32 bits
   localparam int SQ_STEPS   = 4;
   localparam int SD_STAGES  = 8;   // 2 quotient bits per stage, 16 bits
   localparam int SD_STEPS   = 2;
   localparam int PIPE_DEPTH = 2 + ANG_STAGES + TRIG_LAT + 3 + SQ_STAGES + 1 + SD_STAGES;

   typedef struct packed {
      logic [5:0]  rem;
      logic [29:0] low;
      logic [29:0] quo;
   } ang_div_type;

   typedef struct packed {
      logic [33:0] rem;
      logic [31:0] root;
      logic [63:0] val;
   } sqrt_type;

   typedef struct packed {
      logic [30:0] rem;
      logic [15:0] low;
      logic [15:0] quo;
   } scl_div_type;

   // restoring division by the 6-bit grid span
   function automatic ang_div_type ang_div_step(ang_div_type a, logic [5:0] dvs);
      ang_div_type r;
      logic [6:0]  t;
      r = a;
      for (int i = 0; i < ANG_STEPS; i++) begin
         t     = {r.rem, r.low[29]};
         r.low = {r.low[28:0], 1'b0};
         if (t >= {1'b0, dvs}) begin
            r.rem = 6'(t - {1'b0, dvs});
            r.quo = {r.quo[28:0], 1'b1};
         end else begin
            r.rem = t[5:0];
            r.quo = {r.quo[28:0], 1'b0};
         end
      end
      return r;
   endfunction

   // digit-by-digit floor square root, two input bits per step
   function automatic sqrt_type sqrt_step(sqrt_type a);
      sqrt_type    r;
      logic [35:0] t;
      logic [35:0] trial;
      r = a;
      for (int i = 0; i < SQ_STEPS; i++) begin
         t     = {r.rem, r.val[63:62]};
         trial = {2'b00, r.root, 2'b01};
         r.val = {r.val[61:0], 2'b00};
         if (t >= trial) begin
            r.rem  = 34'(t - trial);
            r.root = {r.root[30:0], 1'b1};
         end else begin
            r.rem  = t[33:0];
            r.root = {r.root[30:0], 1'b0};
         end
      end
      return r;
   endfunction

   // restoring division by the norm
   function automatic scl_div_type scl_div_step(scl_div_type a, logic [30:0] dvs);
      scl_div_type r;
      logic [31:0] t;
      r = a;
      for (int i = 0; i < SD_STEPS; i++) begin
         t     = {r.rem, r.low[15]};
         r.low = {r.low[14:0], 1'b0};
         if (t >= {1'b0, dvs}) begin
            r.rem = 31'(t - {1'b0, dvs});
            r.quo = {r.quo[14:0], 1'b1};
         end else begin
            r.rem = t[30:0];
            r.quo = {r.quo[14:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ sv/cube_sphere_vertex_gen.sv @@
// ----------------------------------------------------------------------------
// cube_sphere_vertex_gen: six cube-sphere vertices per grid position
// Angles, sin/cos, cross product, norm and scaling in one stalling pipeline,
// then an output stage sending the six faces one per cycle while rsp_tready is high.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  req_    | in        | tdata: row_index, col_index
//  rsp_    | out       | tdata: pos_x, pos_y, pos_z; tuser: face_code; tlast: last_face
//  csr_    | in        | index 0 points_per_row, index 1 sphere_radius
//
//  The output stage sends one face per cycle while rsp_tready is high.
//  One grid position makes six items on the rsp channel, one per face.
//  All stages hold while the last stage and the output stage are full and not draining.
//  Reset clears all valid bits and loads points_per_row 12, radius 794.
// ----------------------------------------------------------------------------
`default_nettype none

module cube_sphere_vertex_gen
   import csvg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [5:0] row_index, [11:6] col_index
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // [15:0] pos_x, [31:16] pos_y, [47:32] pos_z
   output logic [2:0]       rsp_tuser,   // [2:0] face_code
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [14:0] csr_data
);

   localparam int LAST = PIPE_DEPTH - 1;

   logic [6:0]  points_ff;
   logic [14:0] radius_ff;

   logic        vld_ff [0:LAST];
   logic [1:0]  flg_ff [0:LAST];   // [0] neg1 (longitude), [1] neg2 (latitude)

   logic [5:0]  m1_ff;
   logic [5:0]  d1_ff [0:1];
   logic [5:0]  m2_ff;
   logic [35:0] n2_ff [0:1];
   ang_div_type ad_ff [0:ANG_STAGES-1][0:1];
   logic [5:0]  md_ff [0:ANG_STAGES-2];

   logic [14:0] sin_w [0:1];
   logic [14:0] cos_w [0:1];

   logic [29:0] v_ff [0:2];
   logic [29:0] vb_ff [0:2];
   logic [59:0] sq_ff [0:2];
   logic [29:0] vc_ff [0:2];
   logic [61:0] sum_ff;
   sqrt_type    rt_ff [0:SQ_STAGES-1];
   logic [29:0] rv_ff [0:SQ_STAGES-1][0:2];
   logic [45:0] pr_ff [0:2];
   logic [30:0] nm_ff;
   scl_div_type sd_ff [0:SD_STAGES-1][0:2];
   logic [30:0] sn_ff [0:SD_STAGES-1];

   logic        ser_vld_ff;
   logic [2:0]  face_ff;
   logic signed [15:0] p_ff [0:2];

   logic        pipe_en, ser_free, ser_load, rsp_fire;
   logic [6:0]  n_clamp;
   logic [5:0]  m_in, row_in, col_in, d_lon_in, d_lat_in;
   logic [6:0]  row2, col2;
   logic        neg1_in, neg2_in;
   logic signed [15:0] p_in [0:2];
   logic signed [15:0] ox, oy, oz;

   // grid span and signed step offsets
   always_comb begin
      if (points_ff < MIN_ROW_POINTS)      n_clamp = MIN_ROW_POINTS;
      else if (points_ff > MAX_ROW_POINTS) n_clamp = MAX_ROW_POINTS;
      else                                 n_clamp = points_ff;
      m_in   = 6'(n_clamp - 7'd1);
      row_in = (req_tdata[5:0] > m_in) ? m_in : req_tdata[5:0];
      col_in = (req_tdata[11:6] > m_in) ? m_in : req_tdata[11:6];
      row2   = {row_in, 1'b0};
      col2   = {col_in, 1'b0};
      neg2_in  = row2 > {1'b0, m_in};
      d_lat_in = neg2_in ? 6'(row2 - {1'b0, m_in}) : 6'({1'b0, m_in} - row2);
      neg1_in  = col2 < {1'b0, m_in};
      d_lon_in = neg1_in ? 6'({1'b0, m_in} - col2) : 6'(col2 - {1'b0, m_in});
   end

   // handshake and stall control
   assign rsp_fire   = ser_vld_ff && rsp_tready;
   assign ser_free   = !ser_vld_ff || (rsp_tready && face_ff == FACE_NZ);
   assign pipe_en    = !vld_ff[LAST] || ser_free;
   assign ser_load   = pipe_en && vld_ff[LAST];
   assign req_tready = pipe_en;
   assign csr_ready  = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff <= POINTS_RESET;
         radius_ff <= RADIUS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_POINTS: points_ff <= csr_data[6:0];
            CSR_RADIUS: radius_ff <= csr_data;
            default:    ;
         endcase
      end
   end

   // valid bits and sign flags travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAST; i++) vld_ff[i] <= 1'b0;
      end else if (pipe_en) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i <= LAST; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         flg_ff[0] <= {neg2_in, neg1_in};
         for (int i = 1; i <= LAST; i++) flg_ff[i] <= flg_ff[i-1];
      end
   end

   // angle magnitudes: (pi/4 * d + m/2) / m
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         m1_ff    <= m_in;
         d1_ff[0] <= d_lon_in;
         d1_ff[1] <= d_lat_in;
         m2_ff    <= m1_ff;
         for (int l = 0; l < 2; l++) begin
            n2_ff[l] <= PI4_Q30 * d1_ff[l] + {31'd0, m1_ff[5:1]};
            ad_ff[0][l] <= ang_div_step('{rem: n2_ff[l][35:30], low: n2_ff[l][29:0],
                                           quo: 30'd0}, m2_ff);
         end
         md_ff[0] <= m2_ff;
         for (int s = 1; s < ANG_STAGES - 1; s++) md_ff[s] <= md_ff[s-1];
         for (int s = 1; s < ANG_STAGES; s++) begin
            for (int l = 0; l < 2; l++) begin
               ad_ff[s][l] <= ang_div_step(ad_ff[s-1][l], md_ff[s-1]);
            end
         end
      end
   end

   // trig lanes: lane 0 longitude, lane 1 latitude
   for (genvar l = 0; l < 2; l++) begin : g_trig
      csvg_sincos u_sincos (
         .clock   (clock),
         .pipe_en (pipe_en),
         .angle   (ad_ff[ANG_STAGES-1][l].quo),
         .sin_val (sin_w[l]),
         .cos_val (cos_w[l])
      );
   end

   // cross product, squares, sum, square root
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         v_ff[0] <= cos_w[0] * cos_w[1];
         v_ff[1] <= cos_w[0] * sin_w[1];
         v_ff[2] <= sin_w[0] * cos_w[1];
         for (int k = 0; k < 3; k++) begin
            sq_ff[k] <= v_ff[k] * v_ff[k];
            vb_ff[k] <= v_ff[k];
            vc_ff[k] <= vb_ff[k];
         end
         sum_ff <= {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};
         rt_ff[0] <= sqrt_step('{rem: 34'd0, root: 32'd0, val: {2'b00, sum_ff}});
         for (int k = 0; k < 3; k++) rv_ff[0][k] <= vc_ff[k];
         for (int s = 1; s < SQ_STAGES; s++) begin
            rt_ff[s] <= sqrt_step(rt_ff[s-1]);
            for (int k = 0; k < 3; k++) rv_ff[s][k] <= rv_ff[s-1][k];
         end
      end
   end

   // scaling: (|v| * radius + norm/2) / norm
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int k = 0; k < 3; k++) begin
            pr_ff[k] <= rv_ff[SQ_STAGES-1][k] * radius_ff
                        + {16'd0, rt_ff[SQ_STAGES-1].root[30:1]};
         end
         nm_ff <= rt_ff[SQ_STAGES-1].root[30:0];
         for (int k = 0; k < 3; k++) begin
            sd_ff[0][k] <= scl_div_step('{rem: {1'b0, pr_ff[k][45:16]},
                                           low: pr_ff[k][15:0], quo: 16'd0}, nm_ff);
         end
         sn_ff[0] <= nm_ff;
         for (int s = 1; s < SD_STAGES; s++) begin
            sn_ff[s] <= sn_ff[s-1];
            for (int k = 0; k < 3; k++) begin
               sd_ff[s][k] <= scl_div_step(sd_ff[s-1][k], sn_ff[s-1]);
            end
         end
      end
   end

   // saturate and sign the three base coordinates
   always_comb begin
      logic [15:0] q;
      logic        neg;
      for (int k = 0; k < 3; k++) begin
         q = sd_ff[SD_STAGES-1][k].quo;
         if (sn_ff[SD_STAGES-1] == 31'd0)   q = 16'd0;
         else if (q > {1'b0, Q15_MAX})       q = {1'b0, Q15_MAX};
         case (k)
            1:       neg = flg_ff[LAST][1];
            2:       neg = !flg_ff[LAST][0];
            default: neg = 1'b0;
         endcase
         p_in[k] = neg ? -$signed(q) : $signed(q);
      end
   end

   // output stage: one face per item
   always_ff @(posedge clock) begin
      if (reset) begin
         ser_vld_ff <= 1'b0;
         face_ff    <= FACE_PX;
      end else begin
         if (ser_load) begin
            ser_vld_ff <= 1'b1;
            face_ff    <= FACE_PX;
         end else if (rsp_fire) begin
            if (face_ff == FACE_NZ) ser_vld_ff <= 1'b0;
            else                    face_ff <= 3'(face_ff + 3'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ser_load) begin
         for (int k = 0; k < 3; k++) p_ff[k] <= p_in[k];
      end
   end

   // per-face permutation and negation
   always_comb begin
      case (face_ff)
         FACE_PX: begin ox =  p_ff[0]; oy =  p_ff[1]; oz =  p_ff[2]; end
         FACE_NX: begin ox = -p_ff[0]; oy =  p_ff[1]; oz = -p_ff[2]; end
         FACE_PY: begin ox = -p_ff[2]; oy =  p_ff[0]; oz = -p_ff[1]; end
         FACE_NY: begin ox =  p_ff[2]; oy = -p_ff[0]; oz =  p_ff[1]; end
         FACE_PZ: begin ox =  p_ff[2]; oy =  p_ff[1]; oz = -p_ff[0]; end
         FACE_NZ: begin ox = -p_ff[2]; oy =  p_ff[1]; oz =  p_ff[0]; end
         default: begin ox =  p_ff[0]; oy =  p_ff[1]; oz =  p_ff[2]; end
      endcase
   end

   assign rsp_tvalid = ser_vld_ff;
   assign rsp_tdata  = {oz, oy, ox};
   assign rsp_tuser  = face_ff;
   assign rsp_tlast  = face_ff == FACE_NZ;

endmodule

`default_nettype wire

@@ sv/csvg_sincos.sv @@
// ----------------------------------------------------------------------------
// csvg_sincos: pipelined sine and cosine of a Q0.30 angle
// Horner-form Taylor series, one multiplier per path per stage, Q0.15 out.
// ----------------------------------------------------------------------------
`default_nettype none

module csvg_sincos
   import csvg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        pipe_en,
   input  wire logic [29:0] angle,
   output logic [14:0]      sin_val,
   output logic [14:0]      cos_val
);

   logic [29:0] x1_ff, x2_ff, x3_ff, x4_ff, x5_ff, x6_ff;
   logic [29:0] sq1_ff, sq2_ff, sq3_ff, sq4_ff, sq5_ff, sq6_ff;
   logic [29:0] qs2_ff, ps3_ff, qs4_ff, ps5_ff, qs6_ff, ps7_ff;
   logic [29:0] qc2_ff, pc3_ff, qc4_ff, pc5_ff, qc6_ff, pc7_ff;
   logic [14:0] sin_ff, cos_ff;

   logic [59:0] sq_prod;
   logic [60:0] qs2_prod, qc2_prod, ps3_prod, pc3_prod, qs4_prod, qc4_prod;
   logic [60:0] ps5_prod, pc5_prod, qs6_prod, qc6_prod, ps7_prod, pc7_prod;
   logic [30:0] s_rnd;
   logic [31:0] c_rnd;
   logic [30:0] c_t;

   always_comb begin
      sq_prod  = angle * angle;
      qs2_prod = sq1_ff * RCP_42;
      qc2_prod = sq1_ff * RCP_56;
      ps3_prod = sq2_ff * (ONE_Q30 - {1'b0, qs2_ff});
      pc3_prod = sq2_ff * (ONE_Q30 - {1'b0, qc2_ff});
      qs4_prod = ps3_ff * RCP_20;
      qc4_prod = pc3_ff * RCP_30;
      ps5_prod = sq4_ff * (ONE_Q30 - {1'b0, qs4_ff});
      pc5_prod = sq4_ff * (ONE_Q30 - {1'b0, qc4_ff});
      qs6_prod = ps5_ff * RCP_6;
      qc6_prod = pc5_ff * RCP_12;
      ps7_prod = x6_ff * (ONE_Q30 - {1'b0, qs6_ff});
      pc7_prod = sq6_ff * (ONE_Q30 - {1'b0, qc6_ff});
      // final rounding to Q0.15
      s_rnd    = {1'b0, ps7_ff} + 31'd16384;
      c_t      = ONE_Q30 - {2'b00, pc7_ff[29:1]};
      c_rnd    = {1'b0, c_t} + 32'd16384;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         x1_ff  <= angle;
         sq1_ff <= sq_prod[59:30];
         x2_ff  <= x1_ff;   sq2_ff <= sq1_ff;
         qs2_ff <= 30'(qs2_prod >> 36);
         qc2_ff <= 30'(qc2_prod >> 36);
         x3_ff  <= x2_ff;   sq3_ff <= sq2_ff;
         ps3_ff <= ps3_prod[59:30];
         pc3_ff <= pc3_prod[59:30];
         x4_ff  <= x3_ff;   sq4_ff <= sq3_ff;
         qs4_ff <= 30'(qs4_prod >> 35);
         qc4_ff <= 30'(qc4_prod >> 35);
         x5_ff  <= x4_ff;   sq5_ff <= sq4_ff;
         ps5_ff <= ps5_prod[59:30];
         pc5_ff <= pc5_prod[59:30];
         x6_ff  <= x5_ff;   sq6_ff <= sq5_ff;
         qs6_ff <= 30'(qs6_prod >> 33);
         qc6_ff <= 30'(qc6_prod >> 34);
         ps7_ff <= ps7_prod[59:30];
         pc7_ff <= pc7_prod[59:30];
         sin_ff <= (s_rnd[30:15] > {1'b0, Q15_MAX}) ? Q15_MAX : s_rnd[29:15];
         cos_ff <= (c_rnd[31:15] > {2'b00, Q15_MAX}) ? Q15_MAX : c_rnd[29:15];
      end
   end

   assign sin_val = sin_ff;
   assign cos_val = cos_ff;

endmodule

`default_nettype wire

@@ test/cube_sphere_vertex_gen_test.sv @@
// ----------------------------------------------------------------------------
// cube_sphere_vertex_gen_test: self-checking bench for the vertex generator
// Drives grid positions under several grid sizes and radii, predicts the six
// vertices of each one in fixed point and checks every result item in order.
// ----------------------------------------------------------------------------
`default_nettype none

module cube_sphere_vertex_gen_test
   import csvg_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 60;

   typedef struct {
      logic [2:0]  face;
      logic [15:0] px;
      logic [15:0] py;
      logic [15:0] pz;
      logic        last;
   } vertex_type;

   typedef struct {
      bit [5:0] row;
      bit [5:0] col;
      bit       typed;   // expected coordinates typed in below
      bit [15:0] p0;
      bit [15:0] p1;
      bit [15:0] p2;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [14:0] csr_data;

   vertex_type vertex_queue[$];
   int         errors;
   int         cycles;
   int         send_idle_pct;
   int         recv_stall_pct;
   int         hold_off_cycles;
   logic [6:0]  grid_points;
   logic [14:0] radius;

   cube_sphere_vertex_gen uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // cycle counter and timeout
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Q0.15 sine, Horner series to x^7
   function automatic longint unsigned sin_q15(longint unsigned x);
      longint unsigned x2, t, r;
      x2 = (x * x) >> 30;
      t  = 64'(ONE_Q30) - x2 / 42;
      t  = 64'(ONE_Q30) - ((x2 * t) >> 30) / 20;
      t  = 64'(ONE_Q30) - ((x2 * t) >> 30) / 6;
      r  = (((x * t) >> 30) + 16384) >> 15;
      return (r > 32767) ? 32767 : r;
   endfunction

   // Q0.15 cosine, Horner series to x^8
   function automatic longint unsigned cos_q15(longint unsigned x);
      longint unsigned x2, t, r;
      x2 = (x * x) >> 30;
      t  = 64'(ONE_Q30) - x2 / 56;
      t  = 64'(ONE_Q30) - ((x2 * t) >> 30) / 30;
      t  = 64'(ONE_Q30) - ((x2 * t) >> 30) / 12;
      t  = 64'(ONE_Q30) - ((x2 * t) >> 30) / 2;
      r  = (t + 16384) >> 15;
      return (r > 32767) ? 32767 : r;
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [15:0] scale_coord(longint unsigned mag, bit neg,
                                                longint unsigned norm);
      longint unsigned q;
      if (norm == 0) return 16'd0;
      q = (mag * radius + norm / 2) / norm;
      if (q > 32767) q = 32767;
      return neg ? 16'(-int'(q)) : 16'(q);
   endfunction

   // queue the six vertices of one grid position
   task automatic predict_vertices(bit [5:0] row_in, bit [5:0] col_in);
      longint unsigned n, m, row, col, d1, d2, a1, a2, s1, c1, s2, c2;
      longint unsigned v0, v1, v2, norm;
      bit neg1, neg2;
      logic [15:0] p[3];
      logic [15:0] xyz[6][3];
      vertex_type vx;
      n = grid_points;
      if (n < MIN_ROW_POINTS) n = MIN_ROW_POINTS;
      if (n > MAX_ROW_POINTS) n = MAX_ROW_POINTS;
      m = n - 1;
      row = (row_in > m) ? m : row_in;
      col = (col_in > m) ? m : col_in;
      neg2 = 2 * row > m;
      d2 = neg2 ? 2 * row - m : m - 2 * row;
      neg1 = 2 * col < m;
      d1 = neg1 ? m - 2 * col : 2 * col - m;
      a2 = (64'(PI4_Q30) * d2 + m / 2) / m;
      a1 = (64'(PI4_Q30) * d1 + m / 2) / m;
      s1 = sin_q15(a1);
      c1 = cos_q15(a1);
      s2 = sin_q15(a2);
      c2 = cos_q15(a2);
      v0 = c1 * c2;
      v1 = c1 * s2;
      v2 = s1 * c2;
      norm = floor_sqrt(v0 * v0 + v1 * v1 + v2 * v2);
      p[0] = scale_coord(v0, 1'b0, norm);
      p[1] = scale_coord(v1, neg2, norm);
      p[2] = scale_coord(v2, !neg1 && v2 != 0, norm);
      xyz[0] = '{p[0], p[1], p[2]};
      xyz[1] = '{-p[0], p[1], -p[2]};
      xyz[2] = '{-p[2], p[0], -p[1]};
      xyz[3] = '{p[2], -p[0], p[1]};
      xyz[4] = '{p[2], p[1], -p[0]};
      xyz[5] = '{-p[2], p[1], p[0]};
      for (int k = 0; k < 6; k++) begin
         vx.face = 3'(k);
         vx.px = xyz[k][0];
         vx.py = xyz[k][1];
         vx.pz = xyz[k][2];
         vx.last = (k == 5);
         vertex_queue = {vertex_queue, vx};
      end
   endtask

   // one register write, only while idle
   task automatic write_csr(logic idx, logic [14:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_POINTS) grid_points = value[6:0];
      else radius = value;
      @(negedge clock);
   endtask

   // offer one grid position and wait for acceptance; valid stays up for
   // a following item and drops only on idle cycles or in wait_drained
   task automatic send_position(bit [5:0] row, bit [5:0] col);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, col, row};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_vertices(row, col);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (vertex_queue.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   // receiver side: random stalls plus one long hold-off
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_off_cycles--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // result checker
   initial begin
      vertex_type want;
      errors = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (vertex_queue.size() == 0) begin
               $display("%0t: unexpected vertex item %h face %0d", $time, rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               want = vertex_queue.pop_front();
               if (rsp_tuser !== want.face || rsp_tlast !== want.last ||
                   rsp_tdata !== {want.pz, want.py, want.px}) begin
                  $display("%0t: expected %0d %0d %h %h %h, got %0d %0d %h %h %h",
                           $time, want.face, want.last, want.px, want.py, want.pz,
                           rsp_tuser, rsp_tlast, rsp_tdata[15:0], rsp_tdata[31:16],
                           rsp_tdata[47:32]);
                  errors++;
               end
            end
         end
      end
   end

   // stimulus
   initial begin
      dir_row_type dir_rows[$];
      int phase_points[6];
      int phase_radius[6];
      bit [5:0] r6, c6;
      int n;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = CSR_POINTS;
      csr_data = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_cycles = 0;
      grid_points = POINTS_RESET;
      radius = RADIUS_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset settings, corners, center-ish, clamped indexes
      dir_rows = {dir_rows, dir_row_type'{6'd0, 6'd0, 1'b0, 16'd0, 16'd0, 16'd0}};
      dir_rows = {dir_rows, dir_row_type'{6'd11, 6'd11, 1'b0, 16'd0, 16'd0, 16'd0}};
      dir_rows = {dir_rows, dir_row_type'{6'd0, 6'd11, 1'b0, 16'd0, 16'd0, 16'd0}};
      dir_rows = {dir_rows, dir_row_type'{6'd11, 6'd0, 1'b0, 16'd0, 16'd0, 16'd0}};
      dir_rows = {dir_rows, dir_row_type'{6'd5, 6'd6, 1'b0, 16'd0, 16'd0, 16'd0}};
      dir_rows = {dir_rows, dir_row_type'{6'd63, 6'd63, 1'b0, 16'd0, 16'd0, 16'd0}};
      dir_rows = {dir_rows, dir_row_type'{6'd63, 6'd0, 1'b0, 16'd0, 16'd0, 16'd0}};
      dir_rows = {dir_rows, dir_row_type'{6'd42, 6'd21, 1'b0, 16'd0, 16'd0, 16'd0}};
      foreach (dir_rows[i]) send_position(dir_rows[i].row, dir_rows[i].col);
      wait_drained();

      // zero radius: every coordinate is zero
      write_csr(CSR_RADIUS, 15'd0);
      dir_rows.delete();
      dir_rows = {dir_rows, dir_row_type'{6'd0, 6'd0, 1'b1, 16'd0, 16'd0, 16'd0}};
      dir_rows = {dir_rows, dir_row_type'{6'd63, 6'd63, 1'b1, 16'd0, 16'd0, 16'd0}};
      foreach (dir_rows[i]) begin
         send_position(dir_rows[i].row, dir_rows[i].col);
         if (dir_rows[i].typed)
            for (int k = vertex_queue.size() - 6; k < vertex_queue.size(); k++)
               if (vertex_queue[k].px != dir_rows[i].p0 ||
                   vertex_queue[k].py != dir_rows[i].p1 ||
                   vertex_queue[k].pz != dir_rows[i].p2) begin
                  $display("%0t: zero radius prediction wrong", $time);
                  errors++;
               end
      end
      wait_drained();

      // small and large grid extremes
      write_csr(CSR_RADIUS, 15'h7FFF);
      write_csr(CSR_POINTS, 7'd0);
      send_position(6'd0, 6'd0);
      send_position(6'd1, 6'd1);
      send_position(6'd63, 6'd0);
      wait_drained();
      write_csr(CSR_POINTS, 7'd127);
      send_position(6'd0, 6'd63);
      send_position(6'd31, 6'd32);
      send_position(6'd63, 6'd0);
      wait_drained();
      write_csr(CSR_POINTS, 7'd2);
      send_position(6'd0, 6'd1);
      send_position(6'd1, 6'd0);
      wait_drained();

      // long receiver hold-off with the sender pushing past the pipeline depth
      write_csr(CSR_POINTS, 7'd64);
      write_csr(CSR_RADIUS, 15'd256);
      hold_off_cycles = 400;
      for (int i = 0; i < 60; i++) send_position(6'($urandom), 6'($urandom));
      wait_drained();

      // random phases with different idling
      phase_points = '{12, 64, 2, 33, 100, 7};
      phase_radius = '{794, 32767, 1, 12000, 500, 20000};
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(CSR_POINTS, 7'(phase_points[ph]));
         write_csr(CSR_RADIUS, 15'(phase_radius[ph] + $urandom_range(3)));
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
         endcase
         n = (ph == 1 || ph == 2) ? 40 : 65;
         for (int i = 0; i < n; i++) begin
            r6 = 6'($urandom);
            c6 = 6'($urandom);
            // mostly in-grid positions, some clamped
            if ($urandom_range(9) < 8 && phase_points[ph] < 64) begin
               r6 = 6'($urandom_range(phase_points[ph] - 1));
               c6 = 6'($urandom_range(phase_points[ph] - 1));
            end
            send_position(r6, c6);
         end
         wait_drained();
      end

      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
sv/csvg_pkg.sv
sv/csvg_sincos.sv
sv/cube_sphere_vertex_gen.sv
test/cube_sphere_vertex_gen_test.sv
